FILE: rtl/core/rmc_pkg.sv
// shared types, codes and sizes of the running mean and covariance block
package rmc_pkg;

  localparam int MAX_DIM      = 7;
  localparam int DEF_DIM      = 7;
  localparam int DEF_SMP_BITS = 32;
  localparam int IDX_W        = 3;
  localparam int ADDR_W       = 6;
  localparam int SMP_W        = 32;
  localparam int VAL_W        = 64;
  localparam int CNT_W        = 32;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // operand selection of the shared multiplier and divider
  localparam logic [1:0] OP_TERM  = 2'd0;
  localparam logic [1:0] OP_SCALE = 2'd1;
  localparam logic [1:0] OP_MEAN  = 2'd2;

  localparam logic KIND_MEAN = 1'b0;
  localparam logic KIND_COV  = 1'b1;

  typedef struct packed {
    logic              cap;
    logic              cnt_inc;
    logic              clr;
    logic              dlt_wr;
    logic              ld_di;
    logic              ld_dj;
    logic              cov_rd;
    logic              cov_wr;
    logic              mul_go;
    logic              div_go;
    logic [1:0]        op_sel;
    logic              term_sv;
    logic              mean_wr;
    logic              out_ld;
    logic              out_kind;
    logic              out_last;
    logic [IDX_W-1:0]  didx;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [ADDR_W-1:0] addr;
  } dp_cmd_t;

  typedef struct packed {
    logic n_gt1;
    logic mul_done;
    logic div_done;
    logic out_full;
  } dp_sts_t;

endpackage

FILE: rtl/core/rmc_if.sv
// valid/ready channel interfaces for samples in and statistics out
interface rmc_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      command;
  logic signed [rmc_pkg::SMP_W-1:0] sample_0;
  logic signed [rmc_pkg::SMP_W-1:0] sample_1;
  logic signed [rmc_pkg::SMP_W-1:0] sample_2;
  logic signed [rmc_pkg::SMP_W-1:0] sample_3;
  logic signed [rmc_pkg::SMP_W-1:0] sample_4;
  logic signed [rmc_pkg::SMP_W-1:0] sample_5;
  logic signed [rmc_pkg::SMP_W-1:0] sample_6;
  modport source (output valid, command, sample_0, sample_1, sample_2, sample_3,
                  sample_4, sample_5, sample_6, input ready);
  modport sink (input valid, command, sample_0, sample_1, sample_2, sample_3,
                sample_4, sample_5, sample_6, output ready);
endinterface

interface rmc_out_if;
  logic                             valid;
  logic                             ready;
  logic                             entry_kind;
  logic [rmc_pkg::IDX_W-1:0]        row;
  logic [rmc_pkg::IDX_W-1:0]        col;
  logic signed [rmc_pkg::VAL_W-1:0] value;
  logic [rmc_pkg::CNT_W-1:0]        count;
  logic                             last;
  modport source (output valid, entry_kind, row, col, value, count, last, input ready);
  modport sink (input valid, entry_kind, row, col, value, count, last, output ready);
endinterface

FILE: rtl/core/rmc_ctrl.sv
// sequencer for add, read and clear transactions
module rmc_ctrl #(
  parameter int DIM = rmc_pkg::DEF_DIM
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_cmd,
  output logic             in_ready,
  input  rmc_pkg::dp_sts_t sts,
  output rmc_pkg::dp_cmd_t cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DLT  = 5'd1;
  localparam logic [4:0] S_CLDI = 5'd2;
  localparam logic [4:0] S_CLDJ = 5'd3;
  localparam logic [4:0] S_M1G  = 5'd4;
  localparam logic [4:0] S_M1W  = 5'd5;
  localparam logic [4:0] S_D1G  = 5'd6;
  localparam logic [4:0] S_D1W  = 5'd7;
  localparam logic [4:0] S_M2G  = 5'd8;
  localparam logic [4:0] S_M2W  = 5'd9;
  localparam logic [4:0] S_D2G  = 5'd10;
  localparam logic [4:0] S_D2W  = 5'd11;
  localparam logic [4:0] S_CWR  = 5'd12;
  localparam logic [4:0] S_MLD  = 5'd13;
  localparam logic [4:0] S_MDG  = 5'd14;
  localparam logic [4:0] S_MDW  = 5'd15;
  localparam logic [4:0] S_MWR  = 5'd16;
  localparam logic [4:0] S_RMN  = 5'd17;
  localparam logic [4:0] S_RCR  = 5'd18;
  localparam logic [4:0] S_RCO  = 5'd19;

  localparam logic [rmc_pkg::IDX_W-1:0]  LAST_IDX = rmc_pkg::IDX_W'(DIM - 1);
  localparam logic [rmc_pkg::ADDR_W-1:0] LAST_E   = rmc_pkg::ADDR_W'(DIM * DIM - 1);

  logic [4:0]                  state_r, state_nxt;
  logic [rmc_pkg::IDX_W-1:0]   row_r, row_nxt, col_r, col_nxt;
  logic [rmc_pkg::ADDR_W-1:0]  e_r, e_nxt;
  logic                        acc;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      e_r     <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      e_r     <= e_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    e_nxt     = e_r;
    cmd       = '0;
    cmd.row   = row_r;
    cmd.col   = col_r;
    cmd.addr  = e_r;
    cmd.didx  = row_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.cap = 1'b1;
          row_nxt = '0;
          col_nxt = '0;
          e_nxt   = '0;
          priority if (in_cmd == rmc_pkg::CMD_ADD) begin
            cmd.cnt_inc = 1'b1;
            state_nxt   = S_DLT;
          end else if (in_cmd == rmc_pkg::CMD_READ) begin
            state_nxt = S_RMN;
          end else if (in_cmd == rmc_pkg::CMD_CLEAR) begin
            cmd.clr = 1'b1;
          end else begin
            // unused command is dropped
            state_nxt = S_IDLE;
          end
        end
      end
      S_DLT: begin
        cmd.dlt_wr = 1'b1;
        if (row_r == LAST_IDX) begin
          row_nxt   = '0;
          state_nxt = sts.n_gt1 ? S_CLDI : S_MLD;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end
      S_CLDI: begin
        cmd.ld_di  = 1'b1;
        cmd.cov_rd = 1'b1;
        state_nxt  = S_CLDJ;
      end
      S_CLDJ: begin
        cmd.ld_dj = 1'b1;
        cmd.didx  = col_r;
        state_nxt = S_M1G;
      end
      S_M1G: begin
        cmd.mul_go = 1'b1;
        cmd.op_sel = rmc_pkg::OP_TERM;
        state_nxt  = S_M1W;
      end
      S_M1W: if (sts.mul_done) state_nxt = S_D1G;
      S_D1G: begin
        cmd.div_go = 1'b1;
        cmd.op_sel = rmc_pkg::OP_TERM;
        state_nxt  = S_D1W;
      end
      S_D1W: if (sts.div_done) state_nxt = S_M2G;
      S_M2G: begin
        cmd.term_sv = 1'b1;
        cmd.mul_go  = 1'b1;
        cmd.op_sel  = rmc_pkg::OP_SCALE;
        state_nxt   = S_M2W;
      end
      S_M2W: if (sts.mul_done) state_nxt = S_D2G;
      S_D2G: begin
        cmd.div_go = 1'b1;
        cmd.op_sel = rmc_pkg::OP_SCALE;
        state_nxt  = S_D2W;
      end
      S_D2W: if (sts.div_done) state_nxt = S_CWR;
      S_CWR: begin
        cmd.cov_wr = 1'b1;
        e_nxt      = e_r + 1'b1;
        if (col_r == LAST_IDX) begin
          col_nxt = '0;
          if (row_r == LAST_IDX) begin
            row_nxt   = '0;
            state_nxt = S_MLD;
          end else begin
            row_nxt   = row_r + 1'b1;
            state_nxt = S_CLDI;
          end
        end else begin
          col_nxt   = col_r + 1'b1;
          state_nxt = S_CLDI;
        end
      end
      S_MLD: begin
        cmd.ld_di = 1'b1;
        state_nxt = S_MDG;
      end
      S_MDG: begin
        cmd.div_go = 1'b1;
        cmd.op_sel = rmc_pkg::OP_MEAN;
        state_nxt  = S_MDW;
      end
      S_MDW: if (sts.div_done) state_nxt = S_MWR;
      S_MWR: begin
        cmd.mean_wr = 1'b1;
        if (row_r == LAST_IDX) begin
          row_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          row_nxt   = row_r + 1'b1;
          state_nxt = S_MLD;
        end
      end
      S_RMN: begin
        if (!sts.out_full) begin
          cmd.out_ld   = 1'b1;
          cmd.out_kind = rmc_pkg::KIND_MEAN;
          cmd.col      = '0;
          if (row_r == LAST_IDX) begin
            row_nxt   = '0;
            state_nxt = S_RCR;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end
      end
      S_RCR: begin
        cmd.cov_rd = 1'b1;
        state_nxt  = S_RCO;
      end
      S_RCO: begin
        if (!sts.out_full) begin
          cmd.out_ld   = 1'b1;
          cmd.out_kind = rmc_pkg::KIND_COV;
          cmd.out_last = (e_r == LAST_E);
          e_nxt        = e_r + 1'b1;
          if (col_r == LAST_IDX) begin
            col_nxt = '0;
            row_nxt = row_r + 1'b1;
          end else begin
            col_nxt = col_r + 1'b1;
          end
          state_nxt = (e_r == LAST_E) ? S_IDLE : S_RCR;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/rmc_dpath.sv
// statistics storage, shift-add multiplier, restoring divider and output register
module rmc_dpath #(
  parameter int DIM      = rmc_pkg::DEF_DIM,
  parameter int SMP_BITS = rmc_pkg::DEF_SMP_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rmc_pkg::dp_cmd_t                  cmd,
  output rmc_pkg::dp_sts_t                  sts,
  input  logic signed [rmc_pkg::SMP_W-1:0]  smp_i [rmc_pkg::MAX_DIM],
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_kind,
  output logic [rmc_pkg::IDX_W-1:0]         out_row,
  output logic [rmc_pkg::IDX_W-1:0]         out_col,
  output logic signed [rmc_pkg::VAL_W-1:0]  out_value,
  output logic [rmc_pkg::CNT_W-1:0]         out_count,
  output logic                              out_last
);

  localparam int MI_W  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int NE    = DIM * DIM;
  localparam int CA_W  = (NE > 1) ? $clog2(NE) : 1;
  localparam int DW    = rmc_pkg::SMP_W + 1;
  localparam int VW    = rmc_pkg::VAL_W;
  localparam int CW    = rmc_pkg::CNT_W;
  localparam int PW    = VW + DW;
  localparam int QW    = VW + CW;

  logic [SMP_BITS-1:0]     smp_r   [DIM];
  logic [CW-1:0]           mean_r  [DIM];
  logic signed [DW-1:0]    delta_r [DIM];
  logic [VW-1:0]           cov_mem [NE];
  logic [NE-1:0]           cov_vld_r;
  logic [VW-1:0]           cov_q_r;
  logic                    cov_qv_r;
  logic [VW-1:0]           cov_val;
  logic [CW-1:0]           cnt_r;
  logic signed [DW-1:0]    di_r, dj_r;
  logic [VW-1:0]           term_r;

  logic [MI_W-1:0]         mi;
  logic [CA_W-1:0]         ca;
  logic signed [DW-1:0]    dsel, x_ext, m_ext;

  logic [PW-1:0]           mul_prod_r;
  logic [VW-1:0]           mul_a_r;
  logic [5:0]              mul_cnt_r;
  logic                    mul_busy_r;
  logic [VW:0]             mul_sum;
  logic [VW-1:0]           mul_a;
  logic [DW-1:0]           mul_b;
  logic                    mul_fin;

  logic [QW-1:0]           dvd_r;
  logic [CW-1:0]           rem_r, dvs_r;
  logic                    neg_r, div_busy_r;
  logic [6:0]              div_cnt_r, div_end_r;
  logic [CW:0]             div_t, div_d;
  logic                    div_ge, div_fin;
  logic [VW-1:0]           quo;
  logic [VW-1:0]           sc_sum, cov_new;

  logic [DW-1:0]           mag_di, mag_dj;
  logic [VW-1:0]           mag_c;

  assign mi = cmd.didx[MI_W-1:0];
  assign ca = cmd.addr[CA_W-1:0];

  assign x_ext = DW'($signed(smp_r[mi]));
  assign m_ext = DW'($signed(mean_r[mi]));
  assign dsel  = x_ext - m_ext;

  assign mag_di  = di_r[DW-1] ? DW'(-di_r) : DW'(di_r);
  assign mag_dj  = dj_r[DW-1] ? DW'(-dj_r) : DW'(dj_r);
  assign cov_val = cov_qv_r ? cov_q_r : '0;
  assign mag_c   = cov_val[VW-1] ? (VW'(0) - cov_val) : cov_val;

  // sample capture, count, means and deltas
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      for (int k = 0; k < DIM; k++) smp_r[k] <= smp_i[k][SMP_BITS-1:0];
    end
    if (cmd.dlt_wr) delta_r[mi] <= dsel;
    if (cmd.ld_di) di_r <= delta_r[mi];
    if (cmd.ld_dj) dj_r <= delta_r[mi];
    if (cmd.term_sv) term_r <= quo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      cnt_r <= '0;
      for (int k = 0; k < DIM; k++) mean_r[k] <= '0;
    end else begin
      if (cmd.cnt_inc && (cnt_r != {CW{1'b1}})) cnt_r <= cnt_r + 1'b1;
      if (cmd.mean_wr) mean_r[mi] <= mean_r[mi] + quo[CW-1:0];
    end
  end

  // covariance store with one valid bit per entry
  assign sc_sum  = quo + term_r;
  assign cov_new = ((quo[VW-1] == term_r[VW-1]) && (sc_sum[VW-1] != quo[VW-1])) ?
                   (quo[VW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}}) :
                   sc_sum;

  always_ff @(posedge clk) begin
    if (cmd.cov_wr) cov_mem[ca] <= cov_new;
    if (cmd.cov_rd) cov_q_r <= cov_mem[ca];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      cov_vld_r <= '0;
      cov_qv_r  <= 1'b0;
    end else begin
      if (cmd.cov_wr) cov_vld_r[ca] <= 1'b1;
      if (cmd.cov_rd) cov_qv_r <= cov_vld_r[ca];
    end
  end

  // shift-add multiplier, one multiplier bit per cycle
  always_comb begin
    unique case (cmd.op_sel)
      rmc_pkg::OP_SCALE: begin
        mul_a = mag_c;
        mul_b = DW'(cnt_r - CW'(2));
      end
      default: begin
        mul_a = VW'(mag_di);
        mul_b = mag_dj;
      end
    endcase
  end

  assign mul_sum = {1'b0, mul_prod_r[PW-1:DW]} + (mul_prod_r[0] ? {1'b0, mul_a_r} : '0);
  assign mul_fin = mul_busy_r && (mul_cnt_r == 6'(DW - 1));

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      mul_a_r    <= mul_a;
      mul_prod_r <= {{VW{1'b0}}, mul_b};
      mul_cnt_r  <= '0;
    end else if (mul_busy_r) begin
      mul_prod_r <= {mul_sum, mul_prod_r[DW-1:1]};
      mul_cnt_r  <= mul_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mul_busy_r <= 1'b0;
    else if (cmd.mul_go) mul_busy_r <= 1'b1;
    else if (mul_fin) mul_busy_r <= 1'b0;
  end

  // restoring divider, one quotient bit per cycle
  assign div_t   = {rem_r, dvd_r[QW-1]};
  assign div_d   = {1'b0, dvs_r};
  assign div_ge  = (div_t >= div_d);
  assign div_fin = div_busy_r && (div_cnt_r == div_end_r);
  assign quo     = neg_r ? (VW'(0) - dvd_r[VW-1:0]) : dvd_r[VW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      rem_r     <= '0;
      div_cnt_r <= '0;
      unique case (cmd.op_sel)
        rmc_pkg::OP_TERM: begin
          dvd_r     <= {mul_prod_r[VW-1:0], {CW{1'b0}}};
          dvs_r     <= cnt_r;
          neg_r     <= di_r[DW-1] ^ dj_r[DW-1];
          div_end_r <= 7'(VW - 1);
        end
        rmc_pkg::OP_SCALE: begin
          dvd_r     <= mul_prod_r[QW-1:0];
          dvs_r     <= cnt_r - 1'b1;
          neg_r     <= cov_val[VW-1];
          div_end_r <= 7'(QW - 1);
        end
        default: begin
          dvd_r     <= {VW'(mag_di), {CW{1'b0}}};
          dvs_r     <= cnt_r;
          neg_r     <= di_r[DW-1];
          div_end_r <= 7'(VW - 1);
        end
      endcase
    end else if (div_busy_r) begin
      rem_r     <= div_ge ? CW'(div_t - div_d) : div_t[CW-1:0];
      dvd_r     <= {dvd_r[QW-2:0], div_ge};
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) div_busy_r <= 1'b0;
    else if (cmd.div_go) div_busy_r <= 1'b1;
    else if (div_fin) div_busy_r <= 1'b0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_kind  <= cmd.out_kind;
      out_row   <= cmd.row;
      out_col   <= cmd.col;
      out_value <= (cmd.out_kind == rmc_pkg::KIND_COV) ? cov_val :
                   VW'($signed(mean_r[mi]));
      out_count <= cnt_r;
      out_last  <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (cmd.out_ld) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  assign sts.n_gt1    = (cnt_r > CW'(1));
  assign sts.mul_done = mul_fin;
  assign sts.div_done = div_fin;
  assign sts.out_full = out_valid;

  a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_go |-> !mul_busy_r) else $error("multiplier started while busy");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_go |-> !div_busy_r) else $error("divider started while busy");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> !out_valid) else $error("result overwritten before transfer");
  a_cov_n: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cov_wr |-> (cnt_r > CW'(1))) else $error("covariance written with n below two");
  a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy_r |-> (dvs_r != '0)) else $error("divide by zero");

endmodule

FILE: rtl/core/running_mean_covariance_core.sv
// top level of the running mean vector and sample covariance block
// Usage: each input transaction carries a command and DIM signed Q16.16
// samples. add folds the sample into the running statistics, clear zeroes
// count, means and covariances, read streams DIM means then
// DIM*DIM covariances row-major, with last on the final covariance entry.
// Command 3 is ignored. Add and clear give no output transactions.
// One transaction is worked on at a time; in_ch.ready is high only when idle.
// An add stores the deltas, walks the covariance entries and then updates
// the means; the first sample skips the covariance walk.
// Each covariance entry runs a shift-add multiply, a divide by n, a scale
// multiply and a divide by n-1 on one shared multiplier and one shared
// restoring divider, one bit a cycle.
// On a read the result register reloads only in the cycle after its
// transaction leaves, so each covariance entry needs a registered store
// read plus a load. A stall on out_ch holds the result register and the
// sequencer.
// Reset clears count, means and covariance valid bits and empties the
// output register.
module running_mean_covariance_core #(
  parameter int DIM         = rmc_pkg::DEF_DIM,
  parameter int SAMPLE_BITS = rmc_pkg::DEF_SMP_BITS
) (
  input logic      clk,
  input logic      rst_n,
  rmc_in_if.sink   in_ch,
  rmc_out_if.source out_ch
);

  rmc_pkg::dp_cmd_t                 cmd;
  rmc_pkg::dp_sts_t                 sts;
  logic signed [rmc_pkg::SMP_W-1:0] smp [rmc_pkg::MAX_DIM];

  assign smp[0] = in_ch.sample_0;
  assign smp[1] = in_ch.sample_1;
  assign smp[2] = in_ch.sample_2;
  assign smp[3] = in_ch.sample_3;
  assign smp[4] = in_ch.sample_4;
  assign smp[5] = in_ch.sample_5;
  assign smp[6] = in_ch.sample_6;

  rmc_ctrl #(.DIM(DIM)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.command),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rmc_dpath #(.DIM(DIM), .SMP_BITS(SAMPLE_BITS)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .smp_i     (smp),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.entry_kind),
    .out_row   (out_ch.row),
    .out_col   (out_ch.col),
    .out_value (out_ch.value),
    .out_count (out_ch.count),
    .out_last  (out_ch.last)
  );

endmodule
